### design/vap_pkg.sv
package vap_pkg;

  // destination format codes
  localparam logic [3:0] FMT_BYTE4   = 4'd0;
  localparam logic [3:0] FMT_UBYTE4  = 4'd1;
  localparam logic [3:0] FMT_SHORT2  = 4'd2;
  localparam logic [3:0] FMT_USHORT2 = 4'd3;
  localparam logic [3:0] FMT_HALF2   = 4'd4;
  localparam logic [3:0] FMT_HALF4   = 4'd5;
  localparam logic [3:0] FMT_FLOAT1  = 4'd6;
  localparam logic [3:0] FMT_FLOAT4  = 4'd9;
  localparam logic [3:0] FMT_RGB10A2 = 4'd10;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DEST_FORMAT   = 3'd0;
  localparam logic [2:0] REG_SOURCE_DIM    = 3'd1;
  localparam logic [2:0] REG_NORMALIZED    = 3'd2;
  localparam logic [2:0] REG_POSITIVE      = 3'd3;
  localparam logic [2:0] REG_SOURCE_IS_INT = 3'd4;

  localparam int unsigned NUM_LANES = 4;

  // one unit below one in 2^-25 fixed point
  localparam logic signed [43:0] NEG_ONE_LIM = 44'sd33554431;

  typedef struct packed {
    logic [3:0] dest_format;
    logic [2:0] source_dimension;
    logic       normalized_mode;
    logic       positive_range;
    logic       source_is_integer;
  } vap_cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } vap_en_t;

  // scaling for float to integer conversion, fixed point values in 2^-25 units
  typedef struct packed {
    logic [15:0] mult;
    logic [5:0]  lead;
    logic        halve;
    logic [43:0] offset;
    logic [15:0] max_val;
    logic [43:0] sat_lim;
  } vap_scale_t;

  function automatic vap_scale_t scale_of(vap_cfg_t c);
    vap_scale_t s;
    s.mult    = 16'd1;
    s.lead    = 6'd23;
    s.halve   = 1'b0;
    s.offset  = 44'd0;
    s.max_val = 16'd255;
    s.sat_lim = (44'd1 << 33) - 44'd256;
    if (c.dest_format <= FMT_UBYTE4) begin
      if (c.normalized_mode) begin
        s.mult = 16'd255;
        s.lead = 6'd30;
        if (!c.positive_range) begin
          s.halve  = 1'b1;
          s.offset = 44'd255 << 24;
        end
      end
    end else if (c.dest_format <= FMT_USHORT2) begin
      s.max_val = 16'd65535;
      s.sat_lim = (44'd1 << 41) - 44'd65536;
      if (c.normalized_mode) begin
        s.mult   = 16'd65535;
        s.lead   = 6'd38;
        s.halve  = 1'b1;
        s.offset = 44'd65535 << 24;
      end
    end else if (c.dest_format == FMT_RGB10A2) begin
      s.mult    = 16'd1023;
      s.lead    = 6'd32;
      s.max_val = 16'd1023;
      s.sat_lim = (44'd1 << 35) - 44'd1024;
    end
    return s;
  endfunction

  // formats that saturate
  function automatic logic is_conv(logic [3:0] fmt);
    return (fmt <= FMT_USHORT2) || (fmt == FMT_RGB10A2);
  endfunction

  // components in the destination
  function automatic logic [2:0] dest_dim(logic [3:0] fmt);
    logic [2:0] d;
    if (fmt <= FMT_UBYTE4) d = 3'd4;
    else if (fmt <= FMT_HALF2) d = 3'd2;
    else if (fmt == FMT_HALF4) d = 3'd4;
    else if (fmt <= FMT_FLOAT4) d = 3'(fmt - FMT_HALF4);
    else d = 3'd3;
    return d;
  endfunction

  // single to half, round to nearest even
  function automatic logic [15:0] to_half(logic [31:0] b);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] mm;
    logic [4:0]  sh;
    logic [23:0] msk;
    logic [23:0] rem;
    logic [23:0] hv;
    logic [15:0] hm;
    logic [9:0]  nfrac;
    logic [15:0] res;
    sgn   = b[31];
    e     = b[30:23];
    m     = b[22:0];
    mm    = {1'b1, m};
    hm    = 16'd0;
    sh    = 5'd0;
    msk   = 24'd0;
    rem   = 24'd0;
    hv    = 24'd0;
    nfrac = (m != 23'd0) ? (10'h200 | m[22:13]) : 10'd0;
    if (e == 8'hFF) begin
      res = {sgn, 5'h1F, nfrac};
    end else if (e >= 8'd143) begin
      res = {sgn, 15'h7C00};
    end else if (e <= 8'd112) begin
      if (e < 8'd102) begin
        res = {sgn, 15'd0};
      end else begin
        sh  = 5'(8'd126 - e);
        msk = (24'd1 << sh) - 24'd1;
        rem = mm & msk;
        hv  = 24'd1 << (sh - 5'd1);
        hm  = 16'(mm >> sh);
        if ((rem > hv) || ((rem == hv) && hm[0])) hm = hm + 16'd1;
        res = {sgn, 15'd0} | hm;
      end
    end else begin
      hm = {1'b0, 5'(e - 8'd112), m[22:13]};
      if ((m[12:0] > 13'h1000) || ((m[12:0] == 13'h1000) && hm[0])) hm = hm + 16'd1;
      res = {sgn, 15'd0} | hm;
    end
    return res;
  endfunction

endpackage

### design/vap_lane.sv
module vap_lane (
  input  logic              clk,
  input  vap_pkg::vap_en_t  en,
  input  vap_pkg::vap_cfg_t cfg,
  input  logic [31:0]       comp,
  output logic [31:0]       res,
  output logic              sat
);

  vap_pkg::vap_scale_t sc;
  assign sc = vap_pkg::scale_of(cfg);

  // ---------------- stage 1: decode, mantissa multiply, half, int magnitude
  logic [23:0] s1_mant;
  logic [39:0] s1_prod_nxt;
  logic [31:0] s1_mag_nxt;
  logic [4:0]  s1_lz_nxt;

  logic [39:0] s1_prod_r;
  logic [7:0]  s1_exp_r;
  logic        s1_sgn_r;
  logic        s1_nan_r;
  logic        s1_inf_r;
  logic        s1_tiny_r;
  logic [15:0] s1_half_r;
  logic [31:0] s1_raw_r;
  logic [31:0] s1_mag_r;
  logic [4:0]  s1_lz_r;

  assign s1_mant     = {1'b1, comp[22:0]};
  assign s1_prod_nxt = {16'd0, s1_mant} * {24'd0, sc.mult};
  assign s1_mag_nxt  = comp[31] ? (32'd0 - comp) : comp;

  // leading zero count of the integer magnitude
  always_comb begin
    s1_lz_nxt = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (s1_mag_nxt[i]) s1_lz_nxt = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_prod_r <= s1_prod_nxt;
      s1_exp_r  <= comp[30:23];
      s1_sgn_r  <= comp[31];
      s1_nan_r  <= (comp[30:23] == 8'hFF) && (comp[22:0] != 23'd0);
      s1_inf_r  <= (comp[30:23] == 8'hFF) && (comp[22:0] == 23'd0);
      s1_tiny_r <= (comp[30:23] == 8'd0);
      s1_half_r <= vap_pkg::to_half(comp);
      s1_raw_r  <= comp;
      s1_mag_r  <= s1_mag_nxt;
      s1_lz_r   <= s1_lz_nxt;
    end
  end

  // ---------------- stage 2: round product to single, int normalize
  logic [5:0]        s2_lead;
  logic [5:0]        s2_lead_hi;
  logic [4:0]        s2_sh;
  logic [23:0]       s2_pre;
  logic [39:0]       s2_rmask;
  logic [39:0]       s2_rem;
  logic [39:0]       s2_hv;
  logic              s2_up;
  logic [24:0]       s2_sum;
  logic              s2_ovf;
  logic [23:0]       s2_mant_nxt;
  logic signed [9:0] s2_ep_nxt;

  logic [23:0]       s2_mant_r;
  logic signed [9:0] s2_ep_r;
  logic              s2_sgn_r;
  logic              s2_nan_r;
  logic              s2_huge_r;
  logic              s2_small_r;
  logic [15:0]       s2_half_r;
  logic [31:0]       s2_raw_r;
  logic [31:0]       s2_norm_r;
  logic [4:0]        s2_lz_r;

  assign s2_lead_hi  = sc.lead + 6'd1;
  assign s2_lead     = s1_prod_r[s2_lead_hi] ? s2_lead_hi : sc.lead;
  assign s2_sh       = 5'(s2_lead - 6'd23);
  assign s2_pre      = 24'(s1_prod_r >> s2_sh);
  assign s2_rmask    = (40'd1 << s2_sh) - 40'd1;
  assign s2_rem      = s1_prod_r & s2_rmask;
  assign s2_hv       = (s2_sh == 5'd0) ? 40'd0 : (40'd1 << (s2_sh - 5'd1));
  assign s2_up       = (s2_sh != 5'd0) &&
                       ((s2_rem > s2_hv) || ((s2_rem == s2_hv) && s2_pre[0]));
  assign s2_sum      = {1'b0, s2_pre} + 25'(s2_up);
  assign s2_ovf      = s2_sum[24];
  assign s2_mant_nxt = s2_ovf ? 24'h800000 : s2_sum[23:0];
  assign s2_ep_nxt   = $signed(10'({2'b0, s1_exp_r}) + 10'({4'b0, s2_lead}) + 10'(s2_ovf)
                       - 10'd150 - 10'(sc.halve));

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_mant_r  <= s2_mant_nxt;
      s2_ep_r    <= s2_ep_nxt;
      s2_sgn_r   <= s1_sgn_r;
      s2_nan_r   <= s1_nan_r;
      s2_huge_r  <= s1_inf_r || (!s1_tiny_r && !s1_nan_r && (s2_ep_nxt >= 10'sd17));
      s2_small_r <= s1_tiny_r || (s2_ep_nxt < -10'sd30);
      s2_half_r  <= s1_half_r;
      s2_raw_r   <= s1_raw_r;
      s2_norm_r  <= s1_mag_r << s1_lz_r;
      s2_lz_r    <= s1_lz_r;
    end
  end

  // ---------------- stage 3: align to fixed point and add offset, int rounding
  logic signed [9:0]  s3_t;
  logic [69:0]        s3_shifted;
  logic [41:0]        s3_a;
  logic               s3_st;
  logic signed [43:0] s3_val_nxt;
  logic [24:0]        s3_m25;
  logic               s3_iup;
  logic [7:0]         s3_iexp;
  logic [31:0]        s3_flt_nxt;

  logic signed [43:0] s3_val_r;
  logic               s3_st_r;
  logic               s3_sgn_r;
  logic               s3_nan_r;
  logic               s3_huge_r;
  logic [15:0]        s3_half_r;
  logic [31:0]        s3_raw_r;
  logic [31:0]        s3_flt_r;

  assign s3_t       = s2_ep_r + 10'sd30;
  assign s3_shifted = {46'd0, s2_mant_r} << s3_t[5:0];
  assign s3_a       = s2_small_r ? 42'd0 : s3_shifted[69:28];
  assign s3_st      = !s2_small_r && (s3_shifted[27:0] != 28'd0);
  assign s3_val_nxt = s2_sgn_r ?
                      $signed(sc.offset - {2'b0, s3_a} - 44'(s3_st)) :
                      $signed(sc.offset + {2'b0, s3_a});

  assign s3_iup     = s2_norm_r[7] && ((s2_norm_r[6:0] != 7'd0) || s2_norm_r[8]);
  assign s3_m25     = {1'b0, s2_norm_r[31:8]} + 25'(s3_iup);
  assign s3_iexp    = 8'(8'd158 - {3'd0, s2_lz_r}) + 8'(s3_m25[24]);
  assign s3_flt_nxt = (s2_norm_r == 32'd0) ? 32'd0 :
                      {s2_raw_r[31], s3_iexp, (s3_m25[24] ? 23'd0 : s3_m25[22:0])};

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_val_r  <= s3_val_nxt;
      s3_st_r   <= s3_st && s2_sgn_r;
      s3_sgn_r  <= s2_sgn_r;
      s3_nan_r  <= s2_nan_r;
      s3_huge_r <= s2_huge_r;
      s3_half_r <= s2_half_r;
      s3_raw_r  <= s2_raw_r;
      s3_flt_r  <= s3_flt_nxt;
    end
  end

  // ---------------- stage 4: round to single, truncate, saturate, select
  logic signed [43:0] s4_neg;
  logic               s4_has_msb;
  logic [4:0]         s4_tt;
  logic               s4_ones;
  logic [15:0]        s4_val;
  logic               s4_sat;
  logic [31:0]        s4_res_nxt;

  logic [31:0]        s4_res_r;
  logic               s4_sat_r;

  assign s4_neg = s3_val_r + vap_pkg::NEG_ONE_LIM;

  // position of the leading one above one half
  always_comb begin
    s4_has_msb = 1'b0;
    s4_tt      = 5'd0;
    for (int i = 24; i < 42; i++) begin
      if (s3_val_r[i]) begin
        s4_has_msb = 1'b1;
        s4_tt      = 5'(i - 24);
      end
    end
  end

  // fraction bits at and above the rounding point all set
  always_comb begin
    s4_ones = s4_has_msb;
    for (int i = 0; i < 25; i++) begin
      if ((5'(i) >= s4_tt) && !s3_val_r[i]) s4_ones = 1'b0;
    end
  end

  always_comb begin
    s4_val = 16'd0;
    s4_sat = 1'b0;
    if (s3_nan_r) begin
      s4_sat = 1'b1;
    end else if (s3_huge_r) begin
      s4_sat = 1'b1;
      s4_val = s3_sgn_r ? 16'd0 : sc.max_val;
    end else if (s3_val_r < 44'sd0) begin
      s4_sat = (s4_neg < 44'sd0) || ((s4_neg == 44'sd0) && !s3_st_r);
    end else if ($unsigned(s3_val_r) >= sc.sat_lim) begin
      s4_sat = 1'b1;
      s4_val = sc.max_val;
    end else begin
      s4_val = s3_val_r[40:25] + 16'(s4_ones);
    end
  end

  // per format result of this component
  always_comb begin
    if (cfg.source_is_integer) begin
      if (cfg.dest_format <= vap_pkg::FMT_UBYTE4) s4_res_nxt = {24'd0, s3_raw_r[7:0]};
      else s4_res_nxt = s3_flt_r;
    end else if (cfg.dest_format <= vap_pkg::FMT_UBYTE4) begin
      s4_res_nxt = {24'd0, s4_val[7:0]};
    end else if (cfg.dest_format <= vap_pkg::FMT_USHORT2) begin
      s4_res_nxt = {16'd0, s4_val};
    end else if (cfg.dest_format <= vap_pkg::FMT_HALF4) begin
      s4_res_nxt = {16'd0, s3_half_r};
    end else if (cfg.dest_format <= vap_pkg::FMT_FLOAT4) begin
      s4_res_nxt = s3_raw_r;
    end else begin
      s4_res_nxt = {22'd0, s4_val[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_res_r <= s4_res_nxt;
      s4_sat_r <= s4_sat && !cfg.source_is_integer && vap_pkg::is_conv(cfg.dest_format);
    end
  end

  assign res = s4_res_r;
  assign sat = s4_sat_r;

endmodule

### design/vap_merge.sv
module vap_merge (
  input  vap_pkg::vap_cfg_t cfg,
  input  logic [3:0][31:0]  lane_res,
  input  logic [3:0]        lane_sat,
  output logic [3:0][31:0]  words,
  output logic [4:0]        bytes_written,
  output logic [1:0]        status
);

  logic [2:0] ddim;
  logic [2:0] n;
  logic [3:0] lane_on;
  logic       bad;
  logic       any_sat;
  logic [3:0] fmt;

  assign fmt  = cfg.dest_format;
  assign ddim = vap_pkg::dest_dim(fmt);
  assign n    = (cfg.source_dimension < ddim) ? cfg.source_dimension : ddim;

  // lanes that write a component
  always_comb begin
    for (int i = 0; i < 4; i++) lane_on[i] = (3'(i) < n);
  end

  assign bad = (fmt > vap_pkg::FMT_RGB10A2) ||
               (cfg.source_is_integer &&
                !((fmt <= vap_pkg::FMT_UBYTE4) ||
                  ((fmt >= vap_pkg::FMT_FLOAT1) && (fmt <= vap_pkg::FMT_FLOAT4))));
  assign any_sat = |(lane_sat & lane_on);

  // pack lane results into the destination layout
  always_comb begin
    words         = '0;
    bytes_written = 5'd0;
    if (!bad) begin
      if (fmt <= vap_pkg::FMT_UBYTE4) begin
        for (int i = 0; i < 4; i++) begin
          if (lane_on[i]) words[0][8*i +: 8] = lane_res[i][7:0];
        end
        bytes_written = {2'b0, n};
      end else if (fmt <= vap_pkg::FMT_HALF4) begin
        for (int i = 0; i < 4; i++) begin
          if (lane_on[i]) words[i/2][16*(i%2) +: 16] = lane_res[i][15:0];
        end
        bytes_written = {1'b0, n, 1'b0};
      end else if (fmt <= vap_pkg::FMT_FLOAT4) begin
        for (int i = 0; i < 4; i++) begin
          if (lane_on[i]) words[i] = lane_res[i];
        end
        bytes_written = {n, 2'b0};
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (lane_on[i]) words[0][10*i +: 10] = lane_res[i][9:0];
        end
        bytes_written = 5'd4;
      end
    end
  end

  assign status = bad ? vap_pkg::ST_UNSUP : (any_sat ? vap_pkg::ST_SAT : vap_pkg::ST_OK);

endmodule

### design/vertex_attribute_packer.sv
// an accepted request passes through the four lane stages and an output register
// before out_tvalid. throughput: one attribute per cycle without backpressure;
// the four component lanes run in parallel and every stage moves independently,
// so bubbles close up under backpressure
// reset: clears all stage valid bits and loads the register defaults
module vertex_attribute_packer (
  input  logic         clk,
  input  logic         rst_n,
  // x [31:0], y [63:32], z [95:64], w [127:96]
  input  logic [127:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // word0..word3 [127:0], bytes_written [132:128], status [134:133], zero [135]
  output logic [135:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  vap_pkg::vap_cfg_t cfg_r;
  logic [2:0]        reg_idx;
  logic              cfg_wr;

  // register port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_format       <= vap_pkg::FMT_UBYTE4;
      cfg_r.source_dimension  <= 3'd4;
      cfg_r.normalized_mode   <= 1'b0;
      cfg_r.positive_range    <= 1'b0;
      cfg_r.source_is_integer <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        vap_pkg::REG_DEST_FORMAT:   cfg_r.dest_format       <= cfg_pwdata[3:0];
        vap_pkg::REG_SOURCE_DIM:    cfg_r.source_dimension  <= cfg_pwdata[2:0];
        vap_pkg::REG_NORMALIZED:    cfg_r.normalized_mode   <= cfg_pwdata[0];
        vap_pkg::REG_POSITIVE:      cfg_r.positive_range    <= cfg_pwdata[0];
        vap_pkg::REG_SOURCE_IS_INT: cfg_r.source_is_integer <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      vap_pkg::REG_DEST_FORMAT:   cfg_prdata = {28'd0, cfg_r.dest_format};
      vap_pkg::REG_SOURCE_DIM:    cfg_prdata = {29'd0, cfg_r.source_dimension};
      vap_pkg::REG_NORMALIZED:    cfg_prdata = {31'd0, cfg_r.normalized_mode};
      vap_pkg::REG_POSITIVE:      cfg_prdata = {31'd0, cfg_r.positive_range};
      vap_pkg::REG_SOURCE_IS_INT: cfg_prdata = {31'd0, cfg_r.source_is_integer};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // stage valids and per stage advance
  logic [4:0]       vld_r;
  logic [4:0]       rdy;
  vap_pkg::vap_en_t en;

  assign rdy[4] = !vld_r[4] || out_tready;
  assign rdy[3] = !vld_r[3] || rdy[4];
  assign rdy[2] = !vld_r[2] || rdy[3];
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];

  assign in_tready = rdy[0];
  assign en.s1     = rdy[0];
  assign en.s2     = rdy[1];
  assign en.s3     = rdy[2];
  assign en.s4     = rdy[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 5'd0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
      if (rdy[3]) vld_r[3] <= vld_r[2];
      if (rdy[4]) vld_r[4] <= vld_r[3];
    end
  end

  // component lanes
  logic [3:0][31:0] lane_res;
  logic [3:0]       lane_sat;

  for (genvar g = 0; g < vap_pkg::NUM_LANES; g++) begin : g_lane
    vap_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cfg  (cfg_r),
      .comp (in_tdata[32*g +: 32]),
      .res  (lane_res[g]),
      .sat  (lane_sat[g])
    );
  end

  // merge and output register
  logic [3:0][31:0] words;
  logic [4:0]       nbytes;
  logic [1:0]       status;
  logic [3:0][31:0] out_words_r;
  logic [4:0]       out_bytes_r;
  logic [1:0]       out_status_r;

  vap_merge u_merge (
    .cfg           (cfg_r),
    .lane_res      (lane_res),
    .lane_sat      (lane_sat),
    .words         (words),
    .bytes_written (nbytes),
    .status        (status)
  );

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      out_words_r  <= words;
      out_bytes_r  <= nbytes;
      out_status_r <= status;
    end
  end

  assign out_tvalid = vld_r[4];
  assign out_tdata  = {1'b0, out_status_r, out_bytes_r, out_words_r};

  // checks
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status_r == vap_pkg::ST_UNSUP) |->
      (out_words_r == '0) && (out_bytes_r == 5'd0))
    else $error("unsupported result carries data");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_bytes_r <= 5'd16))
    else $error("bytes_written out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> (vld_r == 5'd0))
    else $error("stage valid set after reset");

endmodule
